// ===== design/fpv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_pkg
// Shared types and constants of the fixed-point 3-vector unit.
// ----------------------------------------------------------------------------
package fpv_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned IN_FIELDS  = 11;
  localparam int unsigned OUT_FIELDS = 4;
  localparam int unsigned MODE_BITS  = 4;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD       = 4'd0,
    MODE_SUB       = 4'd1,
    MODE_ADDSCALED = 4'd2,
    MODE_SCALE     = 4'd3,
    MODE_MUL       = 4'd4,
    MODE_MULADD    = 4'd5,
    MODE_CROSS     = 4'd6,
    MODE_DOT       = 4'd7,
    MODE_NORMALIZE = 4'd8,
    MODE_NEGATE    = 4'd9,
    MODE_COPY      = 4'd10,
    MODE_REFLECT   = 4'd11,
    MODE_REFRACT   = 4'd12
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  ok;
  } ctl_t;

endpackage

// ===== design/fpv_dly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_dly
// Enable-gated shift line that carries a word along the pipeline.
// ----------------------------------------------------------------------------
module fpv_dly #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ===== design/fpv_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_mul
// Registered fixed-point multiply: full product, arithmetic shift, wrap.
// ----------------------------------------------------------------------------
module fpv_mul #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [W-1:0] p_o
);

  logic signed [2*W-1:0]   prod;
  logic        [2*W+F-1:0] ext;
  logic signed [W-1:0]     p_q;

  assign prod = a_i * b_i;
  assign ext  = {{F{prod[2*W-1]}}, prod};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ext[F+W-1:F];
    end
  end

  assign p_o = p_q;

endmodule

// ===== design/fpv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_div
// Pipelined restoring divider for (x << F) / y, one quotient bit per stage.
// Division by zero saturates toward the sign of the dividend.
// ----------------------------------------------------------------------------
module fpv_div #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  output logic signed [W-1:0] q_o
);

  localparam int unsigned NB = W + F;

  logic [W-1:0]  r_q [NB+1];
  logic [W-1:0]  q_q [NB+1];
  logic [NB-1:0] n_q [NB+1];
  logic [W-1:0]  d_q [NB+1];
  logic [2:0]    f_q [NB+1];
  logic [W-1:0]  r_d [NB+1];
  logic [W-1:0]  q_d [NB+1];
  logic [W:0]    rs  [NB+1];
  logic [W-1:0]  mx;
  logic [W-1:0]  my;
  logic [W-1:0]  res_d;
  logic [W-1:0]  res_q;

  assign mx = x_i[W-1] ? W'(-x_i) : W'(x_i);
  assign my = y_i[W-1] ? W'(-y_i) : W'(y_i);

  always_comb begin
    r_d[0] = '0;
    q_d[0] = '0;
    rs[0]  = '0;
    for (int j = 1; j <= NB; j++) begin
      rs[j] = {r_q[j-1], n_q[j-1][NB-1]};
      if (rs[j] >= {1'b0, d_q[j-1]}) begin
        r_d[j] = W'(rs[j] - {1'b0, d_q[j-1]});
        q_d[j] = {q_q[j-1][W-2:0], 1'b1};
      end else begin
        r_d[j] = rs[j][W-1:0];
        q_d[j] = {q_q[j-1][W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (f_q[NB][0]) begin
      res_d = f_q[NB][1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (f_q[NB][2]) begin
      res_d = W'(-q_q[NB]);
    end else begin
      res_d = q_q[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= '0;
      q_q[0] <= '0;
      n_q[0] <= {mx, {F{1'b0}}};
      d_q[0] <= my;
      f_q[0] <= {x_i[W-1] ^ y_i[W-1], x_i[W-1], (y_i == '0)};
      for (int j = 1; j <= NB; j++) begin
        r_q[j] <= r_d[j];
        q_q[j] <= q_d[j];
        n_q[j] <= {n_q[j-1][NB-2:0], 1'b0};
        d_q[j] <= d_q[j-1];
        f_q[j] <= f_q[j-1];
      end
      res_q <= res_d;
    end
  end

  assign q_o = res_q;

endmodule

// ===== design/fpv_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_sqrt
// Pipelined digit-by-digit square root of (x << F), one root bit per stage.
// Inputs that are zero or negative give zero.
// ----------------------------------------------------------------------------
module fpv_sqrt #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] x_i,
  output logic signed [W-1:0] q_o
);

  localparam int unsigned RB = (W + F + 1) / 2;
  localparam int unsigned VB = 2 * RB;
  localparam int unsigned MB = (RB > W) ? RB : W;

  logic [RB:0]    rem_q  [RB+1];
  logic [RB-1:0]  root_q [RB+1];
  logic [VB-1:0]  v_q    [RB+1];
  logic [RB:0]    rem_d  [RB+1];
  logic [RB-1:0]  root_d [RB+1];
  logic [RB+2:0]  tmp    [RB+1];
  logic [RB+2:0]  trial  [RB+1];
  logic [MB-1:0]  wide;
  logic [W-1:0]   res_q;
  logic           pos;

  assign pos = !x_i[W-1] && (x_i != '0);

  always_comb begin
    rem_d[0]  = '0;
    root_d[0] = '0;
    tmp[0]    = '0;
    trial[0]  = '0;
    for (int j = 1; j <= RB; j++) begin
      tmp[j]   = {rem_q[j-1], v_q[j-1][VB-1:VB-2]};
      trial[j] = {1'b0, root_q[j-1], 2'b01};
      if (tmp[j] >= trial[j]) begin
        rem_d[j]  = (RB+1)'(tmp[j] - trial[j]);
        root_d[j] = {root_q[j-1][RB-2:0], 1'b1};
      end else begin
        rem_d[j]  = tmp[j][RB:0];
        root_d[j] = {root_q[j-1][RB-2:0], 1'b0};
      end
    end
  end

  assign wide = MB'(root_q[RB]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      v_q[0]    <= pos ? VB'({x_i, {F{1'b0}}}) : '0;
      for (int j = 1; j <= RB; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        v_q[j]    <= {v_q[j-1][VB-3:0], 2'b00};
      end
      res_q <= wide[W-1:0];
    end
  end

  assign q_o = res_q;

endmodule

// ===== design/fpv_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_lane
// One vector component: the element-wise front end and the final combine
// for normalize, reflect and refract.
// ----------------------------------------------------------------------------
module fpv_lane #(
  parameter int unsigned W  = 32,
  parameter int unsigned F  = 16,
  parameter int unsigned F0 = 64
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  fpv_pkg::mode_e      mode_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] c_i,
  input  logic signed [W-1:0] s1_i,
  input  logic signed [W-1:0] an1_i,
  input  logic signed [W-1:0] an2_i,
  input  logic signed [W-1:0] bn1_i,
  input  logic signed [W-1:0] bn2_i,
  input  fpv_pkg::ctl_t       ctl_i,
  input  logic signed [W-1:0] tsel_i,
  input  logic signed [W-1:0] inv_i,
  input  logic signed [W-1:0] eta_i,
  output logic signed [W-1:0] p1_o,
  output logic signed [W-1:0] r_o
);

  import fpv_pkg::*;

  logic signed [W-1:0] m1a, m1b, p1, p2;
  logic signed [W-1:0] a1_q, b1_q, c1_q;
  mode_e               mode1_q;
  logic signed [W-1:0] simp_d, simp_q, simp_f;
  logic signed [W-1:0] a_f, b_f, a_f1_q;
  logic signed [W-1:0] m3a, m3b, m3, m4;
  ctl_t                ctl1_q;
  logic signed [W-1:0] r_d, r_q;

  always_comb begin
    case (mode_i)
      MODE_ADDSCALED: begin m1a = s1_i;  m1b = b_i;   end
      MODE_SCALE:     begin m1a = a_i;   m1b = s1_i;  end
      MODE_CROSS:     begin m1a = an1_i; m1b = bn2_i; end
      MODE_NORMALIZE: begin m1a = a_i;   m1b = a_i;   end
      default:        begin m1a = a_i;   m1b = b_i;   end
    endcase
  end

  fpv_mul #(.W(W), .F(F)) u_m1 (.clk_i, .en_i, .a_i(m1a), .b_i(m1b), .p_o(p1));
  fpv_mul #(.W(W), .F(F)) u_m2 (.clk_i, .en_i, .a_i(an2_i), .b_i(bn1_i), .p_o(p2));

  always_comb begin
    case (mode1_q)
      MODE_ADD:       simp_d = a1_q + b1_q;
      MODE_SUB:       simp_d = a1_q - b1_q;
      MODE_ADDSCALED: simp_d = a1_q + p1;
      MODE_SCALE:     simp_d = p1;
      MODE_MUL:       simp_d = p1;
      MODE_MULADD:    simp_d = p1 + c1_q;
      MODE_CROSS:     simp_d = p1 - p2;
      MODE_NEGATE:    simp_d = -a1_q;
      MODE_COPY:      simp_d = a1_q;
      default:        simp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a_i;
      b1_q    <= b_i;
      c1_q    <= c_i;
      mode1_q <= mode_i;
      simp_q  <= simp_d;
    end
  end

  fpv_dly #(.WIDTH(W), .DEPTH(F0 - 1)) u_simp_dly (
    .clk_i, .en_i, .d_i(simp_q), .q_o(simp_f)
  );
  fpv_dly #(.WIDTH(W), .DEPTH(F0)) u_a_dly (.clk_i, .en_i, .d_i(a_i), .q_o(a_f));
  fpv_dly #(.WIDTH(W), .DEPTH(F0)) u_b_dly (.clk_i, .en_i, .d_i(b_i), .q_o(b_f));

  assign m3a = (ctl_i.mode == MODE_NORMALIZE) ? a_f : b_f;
  assign m3b = (ctl_i.mode == MODE_NORMALIZE) ? inv_i : tsel_i;

  fpv_mul #(.W(W), .F(F)) u_m3 (.clk_i, .en_i, .a_i(m3a), .b_i(m3b), .p_o(m3));
  fpv_mul #(.W(W), .F(F)) u_m4 (.clk_i, .en_i, .a_i(a_f), .b_i(eta_i), .p_o(m4));

  always_comb begin
    case (ctl1_q.mode)
      MODE_NORMALIZE: r_d = ctl1_q.ok ? m3 : a_f1_q;
      MODE_REFLECT:   r_d = a_f1_q - m3;
      MODE_REFRACT:   r_d = ctl1_q.ok ? m3 + m4 : '0;
      default:        r_d = simp_f;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_f1_q <= a_f;
      ctl1_q <= ctl_i;
      r_q    <= r_d;
    end
  end

  assign p1_o = p1;
  assign r_o  = r_q;

endmodule

// ===== design/fixed_point_vec3_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_vec3_unit
// Pipelined fixed-point 3-vector unit: add, scale, products, cross, dot,
// normalize, negate, copy, reflect and refract, one transaction per cycle when not stalled.
//
//   Channel   Dir  Payload                                    Handshake
//   s_*       in   tdata: ax ay az bx by bz cx cy cz s1 s2     tvalid/tready
//                  tuser: mode
//   m_*       out  tdata: rx ry rz dot_value, tuser: ok        tvalid/tready
//
// One transaction enters per cycle while the output is not stalled. The pipeline
// depth is set by the two pipelined dividers and the pipelined square root in
// the normalize/refract path.
// Reset clears only the valid bits of the pipeline.
// A stalled output freezes the whole pipeline, and s_tready_o falls with it.
// ----------------------------------------------------------------------------
module fixed_point_vec3_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // ax, ay, az, bx, by, bz, cx, cy, cz, scalar_one, scalar_two
  input  logic [351:0] s_tdata_i,
  // mode
  input  logic [3:0]   s_tuser_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // rx, ry, rz, dot_value
  output logic [127:0] m_tdata_o,
  // ok
  output logic [0:0]   m_tuser_o
);

  import fpv_pkg::*;

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned LD  = W + F + 2;
  localparam int unsigned LS  = (W + F + 1) / 2 + 2;
  localparam int unsigned E   = LD;
  localparam int unsigned Q   = E + 3 + LS;
  localparam int unsigned F0  = Q + LD;
  localparam int unsigned FS  = F0 + 2;
  localparam logic signed [W-1:0] ONE = W'(1) << F;
  localparam logic signed [W-1:0] TWO = W'(1) << (F + 1);

  logic                en;
  logic [FS:0]         vld_q;
  logic signed [W-1:0] a_q [3];
  logic signed [W-1:0] b_q [3];
  logic signed [W-1:0] c_q [3];
  logic signed [W-1:0] s1_q, s2_q;
  mode_e               mode_q, mode1_q;
  logic signed [W-1:0] p1 [3];
  logic signed [W-1:0] r [3];
  logic signed [W-1:0] dot_d, dot_q, dotv_q, dotv_out;
  logic signed [W-1:0] refl_t, refl_f, cc, om_q, om_e1;
  logic signed [W-1:0] dot_e, dot_s, c1_e, eta, eta_f;
  logic signed [W-1:0] ee, ec, ec_q, fprod, k_q, sq_in, sq, tr_q, tr_f, inv;
  logic signed [W-1:0] tsel;
  logic [3:0]          mode_s_raw, mode_f_raw;
  mode_e               mode_s, mode_f;
  logic                ok_s, ok_f, ok_out;
  ctl_t                ctl_f;

  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;
  assign m_tvalid_o = vld_q[FS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FS-1:0], s_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= W'($signed(s_tdata_i[32*i +: 32]));
        b_q[i] <= W'($signed(s_tdata_i[32*(i+3) +: 32]));
        c_q[i] <= W'($signed(s_tdata_i[32*(i+6) +: 32]));
      end
      s1_q    <= W'($signed(s_tdata_i[319:288]));
      s2_q    <= W'($signed(s_tdata_i[351:320]));
      mode_q  <= mode_e'(s_tuser_i);
      mode1_q <= mode_q;
      dot_q   <= dot_d;
      dotv_q  <= (mode1_q == MODE_DOT) ? dot_d : '0;
      om_q    <= ONE - cc;
      k_q     <= ONE - fprod;
      tr_q    <= ec_q - sq;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    fpv_lane #(.W(W), .F(F), .F0(F0)) u_lane (
      .clk_i,
      .en_i   (en),
      .mode_i (mode_q),
      .a_i    (a_q[i]),
      .b_i    (b_q[i]),
      .c_i    (c_q[i]),
      .s1_i   (s1_q),
      .an1_i  (a_q[(i+1)%3]),
      .an2_i  (a_q[(i+2)%3]),
      .bn1_i  (b_q[(i+1)%3]),
      .bn2_i  (b_q[(i+2)%3]),
      .ctl_i  (ctl_f),
      .tsel_i (tsel),
      .inv_i  (inv),
      .eta_i  (eta_f),
      .p1_o   (p1[i]),
      .r_o    (r[i])
    );
  end

  assign dot_d = p1[0] + p1[1] + p1[2];

  fpv_div #(.W(W), .F(F)) u_eta_div (.clk_i, .en_i(en), .x_i(s1_q), .y_i(s2_q), .q_o(eta));

  fpv_mul #(.W(W), .F(F)) u_refl (.clk_i, .en_i(en), .a_i(TWO), .b_i(dot_q), .p_o(refl_t));
  fpv_mul #(.W(W), .F(F)) u_cc (.clk_i, .en_i(en), .a_i(-dot_q), .b_i(-dot_q), .p_o(cc));

  fpv_dly #(.WIDTH(W), .DEPTH(E - 3)) u_om_dly (.clk_i, .en_i(en), .d_i(om_q), .q_o(om_e1));
  fpv_dly #(.WIDTH(W), .DEPTH(E - 2)) u_dot_dly (.clk_i, .en_i(en), .d_i(dot_q), .q_o(dot_e));
  assign c1_e = -dot_e;

  fpv_mul #(.W(W), .F(F)) u_ee (.clk_i, .en_i(en), .a_i(eta), .b_i(eta), .p_o(ee));
  fpv_mul #(.W(W), .F(F)) u_ec (.clk_i, .en_i(en), .a_i(eta), .b_i(c1_e), .p_o(ec));
  fpv_mul #(.W(W), .F(F)) u_fk (.clk_i, .en_i(en), .a_i(ee), .b_i(om_e1), .p_o(fprod));

  fpv_dly #(.WIDTH(W), .DEPTH(3)) u_dots_dly (.clk_i, .en_i(en), .d_i(dot_e), .q_o(dot_s));
  fpv_dly #(.WIDTH(MODE_BITS), .DEPTH(E + 3)) u_modes_dly (
    .clk_i, .en_i(en), .d_i(mode_q), .q_o(mode_s_raw)
  );
  assign mode_s = mode_e'(mode_s_raw);

  always_comb begin
    case (mode_s)
      MODE_NORMALIZE: ok_s = !dot_s[W-1] && (dot_s != '0);
      MODE_REFRACT:   ok_s = !k_q[W-1];
      MODE_ADD, MODE_SUB, MODE_ADDSCALED, MODE_SCALE, MODE_MUL, MODE_MULADD,
      MODE_CROSS, MODE_DOT, MODE_NEGATE, MODE_COPY, MODE_REFLECT: ok_s = 1'b1;
      default:        ok_s = 1'b0;
    endcase
  end

  assign sq_in = (mode_s == MODE_NORMALIZE) ? dot_s : k_q;

  fpv_sqrt #(.W(W), .F(F)) u_sqrt (.clk_i, .en_i(en), .x_i(sq_in), .q_o(sq));

  fpv_dly #(.WIDTH(W), .DEPTH(LS + 2)) u_ec_dly (.clk_i, .en_i(en), .d_i(ec), .q_o(ec_q));

  fpv_div #(.W(W), .F(F)) u_inv_div (.clk_i, .en_i(en), .x_i(ONE), .y_i(sq), .q_o(inv));

  fpv_dly #(.WIDTH(W), .DEPTH(LD - 1)) u_tr_dly (.clk_i, .en_i(en), .d_i(tr_q), .q_o(tr_f));
  fpv_dly #(.WIDTH(W), .DEPTH(F0 - 3)) u_refl_dly (
    .clk_i, .en_i(en), .d_i(refl_t), .q_o(refl_f)
  );
  fpv_dly #(.WIDTH(W), .DEPTH(F0 - E)) u_eta_dly (.clk_i, .en_i(en), .d_i(eta), .q_o(eta_f));
  fpv_dly #(.WIDTH(MODE_BITS), .DEPTH(LS + LD)) u_modef_dly (
    .clk_i, .en_i(en), .d_i(mode_s_raw), .q_o(mode_f_raw)
  );
  fpv_dly #(.WIDTH(1), .DEPTH(LS + LD)) u_okf_dly (.clk_i, .en_i(en), .d_i(ok_s), .q_o(ok_f));
  fpv_dly #(.WIDTH(1), .DEPTH(2)) u_oko_dly (.clk_i, .en_i(en), .d_i(ok_f), .q_o(ok_out));
  fpv_dly #(.WIDTH(W), .DEPTH(FS - 2)) u_dotv_dly (
    .clk_i, .en_i(en), .d_i(dotv_q), .q_o(dotv_out)
  );

  assign mode_f = mode_e'(mode_f_raw);
  assign ctl_f  = {mode_f, ok_f};
  assign tsel   = (mode_f == MODE_REFRACT) ? tr_f : refl_f;

  assign m_tdata_o = {32'(dotv_out), 32'(r[2]), 32'(r[1]), 32'(r[0])};
  assign m_tuser_o = ok_out;

endmodule

// ===== design/fpv_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_chk
// Port-level checks of the fixed-point 3-vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpv_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tready_o,
  input logic         m_tvalid_o,
  input logic         m_tready_i,
  input logic [127:0] m_tdata_o,
  input logic [0:0]   m_tuser_o
);

  // The input side advances exactly when the output register can move.
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (!m_tvalid_o || m_tready_i))
    else $error("input ready does not track the output register");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result transaction dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result payload changed while stalled");

  // A nonzero dot product only comes from dot mode, whose vector is zero.
  a_dot_vector_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[127:96] != 32'd0) |-> m_tdata_o[95:0] == 96'd0)
    else $error("dot result carries a nonzero vector");

  a_dot_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[127:96] != 32'd0) |-> m_tuser_o[0])
    else $error("dot result flagged as failed");

endmodule

bind fixed_point_vec3_unit fpv_chk u_fpv_chk (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-point 3-vector unit. A software predictor
// computes every result from the accepted input transactions, and a
// scoreboard compares each output transaction in order, field by field.
// Stimulus is a directed set of corner cases, followed by random vector
// operations. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import fpv_pkg::*;

  localparam int unsigned FRAC   = 16;
  localparam int unsigned NRAND  = 800;
  localparam int unsigned WD_MAX = 3000;
  localparam int          ONE    = 1 << FRAC;

  typedef struct {
    logic [3:0] mode;
    int         f [11];  // ax ay az bx by bz cx cy cz s1 s2
  } vec_op_t;

  typedef struct {
    int rx, ry, rz, dv;
    bit ok;
  } vec_res_t;

  function automatic int fx_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return int'(p >>> FRAC);
  endfunction

  function automatic int fx_div(int x, int y);
    longint n;
    if (y == 0) return (x < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    n = longint'(x) <<< FRAC;
    return int'(n / longint'(y));
  endfunction

  function automatic int fx_sqrt(int x);
    longint v, r, c;
    if (x <= 0) return 0;
    v = longint'(x) <<< FRAC;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= v) r = c;
    end
    return int'(r);
  endfunction

  function automatic int fx_dot(int a [3], int b [3]);
    return fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
  endfunction

  function automatic vec_res_t predict_vec_op(vec_op_t op);
    vec_res_t r;
    int a [3], b [3], c [3];
    int s1, s2, t, eta, c1, k;
    for (int i = 0; i < 3; i++) begin
      a[i] = op.f[i];
      b[i] = op.f[3 + i];
      c[i] = op.f[6 + i];
    end
    s1 = op.f[9];
    s2 = op.f[10];
    r = '{0, 0, 0, 0, 1'b1};
    case (op.mode)
      MODE_ADD: begin
        r.rx = a[0] + b[0]; r.ry = a[1] + b[1]; r.rz = a[2] + b[2];
      end
      MODE_SUB: begin
        r.rx = a[0] - b[0]; r.ry = a[1] - b[1]; r.rz = a[2] - b[2];
      end
      MODE_ADDSCALED: begin
        r.rx = a[0] + fx_mul(s1, b[0]);
        r.ry = a[1] + fx_mul(s1, b[1]);
        r.rz = a[2] + fx_mul(s1, b[2]);
      end
      MODE_SCALE: begin
        r.rx = fx_mul(a[0], s1); r.ry = fx_mul(a[1], s1); r.rz = fx_mul(a[2], s1);
      end
      MODE_MUL: begin
        r.rx = fx_mul(a[0], b[0]); r.ry = fx_mul(a[1], b[1]); r.rz = fx_mul(a[2], b[2]);
      end
      MODE_MULADD: begin
        r.rx = fx_mul(a[0], b[0]) + c[0];
        r.ry = fx_mul(a[1], b[1]) + c[1];
        r.rz = fx_mul(a[2], b[2]) + c[2];
      end
      MODE_CROSS: begin
        r.rx = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
        r.ry = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
        r.rz = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
      end
      MODE_DOT: r.dv = fx_dot(a, b);
      MODE_NORMALIZE: begin
        t = fx_dot(a, a);
        if (t <= 0) begin
          r.rx = a[0]; r.ry = a[1]; r.rz = a[2]; r.ok = 1'b0;
        end else begin
          t = fx_div(ONE, fx_sqrt(t));
          r.rx = fx_mul(a[0], t); r.ry = fx_mul(a[1], t); r.rz = fx_mul(a[2], t);
        end
      end
      MODE_NEGATE: begin
        r.rx = -a[0]; r.ry = -a[1]; r.rz = -a[2];
      end
      MODE_COPY: begin
        r.rx = a[0]; r.ry = a[1]; r.rz = a[2];
      end
      MODE_REFLECT: begin
        t = fx_mul(2 * ONE, fx_dot(a, b));
        r.rx = a[0] - fx_mul(b[0], t);
        r.ry = a[1] - fx_mul(b[1], t);
        r.rz = a[2] - fx_mul(b[2], t);
      end
      MODE_REFRACT: begin
        eta = fx_div(s1, s2);
        c1  = -fx_dot(a, b);
        k   = ONE - fx_mul(fx_mul(eta, eta), ONE - fx_mul(c1, c1));
        if (k >= 0) begin
          t = fx_mul(eta, c1) - fx_sqrt(k);
          r.rx = fx_mul(b[0], t) + fx_mul(a[0], eta);
          r.ry = fx_mul(b[1], t) + fx_mul(a[1], eta);
          r.rz = fx_mul(b[2], t) + fx_mul(a[2], eta);
        end else begin
          r.ok = 1'b0;
        end
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  class vec_scoreboard;
    vec_res_t pending_q [$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function void note_op(vec_op_t op);
      pending_q.push_back(predict_vec_op(op));
    endfunction

    function void check_result(vec_res_t got);
      vec_res_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result transaction with no expected result pending");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.rx != exp_r.rx) begin
        $error("rx: expected %0d, actual %0d", exp_r.rx, got.rx); errors++;
      end
      if (got.ry != exp_r.ry) begin
        $error("ry: expected %0d, actual %0d", exp_r.ry, got.ry); errors++;
      end
      if (got.rz != exp_r.rz) begin
        $error("rz: expected %0d, actual %0d", exp_r.rz, got.rz); errors++;
      end
      if (got.dv != exp_r.dv) begin
        $error("dot_value: expected %0d, actual %0d", exp_r.dv, got.dv); errors++;
      end
      if (got.ok != exp_r.ok) begin
        $error("ok: expected %0d, actual %0d", exp_r.ok, got.ok); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [351:0] s_tdata_i = '0;
  logic [3:0]   s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [127:0] m_tdata_o;
  logic [0:0]   m_tuser_o;

  vec_scoreboard sb = new();
  bit            idle_en = 1'b1;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  fixed_point_vec3_unit i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_tready_i <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      m_tready_i <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vec_op_t  op;
    vec_res_t res;
    bit       moved;
    moved = 1'b0;
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      op.mode = s_tuser_i;
      for (int i = 0; i < 11; i++) op.f[i] = s_tdata_i[32*i +: 32];
      sb.note_op(op);
      moved = 1'b1;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      res.rx = m_tdata_o[31:0];
      res.ry = m_tdata_o[63:32];
      res.rz = m_tdata_o[95:64];
      res.dv = m_tdata_o[127:96];
      res.ok = m_tuser_o[0];
      sb.check_result(res);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WD_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_op(vec_op_t op);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op.mode;
    for (int i = 0; i < 11; i++) s_tdata_i[32*i +: 32] <= op.f[i];
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic send_mode(logic [3:0] mode, int f [11]);
    vec_op_t op;
    op.mode = mode;
    op.f = f;
    send_op(op);
  endtask

  function automatic int rand_word(int sel);
    case (sel)
      0: return $urandom();
      1: return $urandom_range(0, 8 * ONE) - 4 * ONE;
      2: return $urandom_range(0, 2 * ONE) - ONE;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  task automatic send_random();
    vec_op_t op;
    int      sel, len;
    op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                           : 4'($urandom_range(0, 12));
    sel = $urandom_range(0, 9);
    sel = (sel < 3) ? 0 : (sel < 6) ? 1 : (sel < 9) ? 2 : 3;
    for (int i = 0; i < 11; i++) op.f[i] = rand_word(sel);
    if ((op.mode == MODE_REFRACT || op.mode == MODE_REFLECT) && sel != 0) begin
      // A third of the time bx is one, else it is halved; indices lie near one so both refract outcomes occur.
      len = $urandom_range(0, 2);
      op.f[3] = (len == 0) ? ONE : op.f[3] / 2;
      op.f[9]  = ONE + $urandom_range(0, ONE / 2) - ONE / 4;
      op.f[10] = ONE + $urandom_range(0, ONE / 2) - ONE / 4;
    end
    send_op(op);
  endtask

  initial begin
    int mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_mode(MODE_ADD,       '{mx, mn, -1, 1, -1, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_SUB,       '{mn, mx, 0, 1, -1, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_ADDSCALED, '{ONE, 0, mx, mx, mn, ONE, 0, 0, 0, mn, 0});
    send_mode(MODE_SCALE,     '{mx, mn, -ONE, 0, 0, 0, 0, 0, 0, mx, 0});
    send_mode(MODE_MUL,       '{mn, mn, mx, mn, mx, mx, 0, 0, 0, 0, 0});
    send_mode(MODE_MULADD,    '{ONE, -ONE, 3, 2*ONE, 5, -1, mx, mn, -1, 0, 0});
    send_mode(MODE_CROSS,     '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_DOT,       '{mx, mn, ONE, mx, mn, ONE, 0, 0, 0, 0, 0});
    send_mode(MODE_NORMALIZE, '{3*ONE, 4*ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_NORMALIZE, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_NORMALIZE, '{mx, mx, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_NORMALIZE, '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_NEGATE,    '{mn, mx, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_COPY,      '{mn, mx, -1, mx, mx, mx, mx, mx, mx, mx, mx});
    send_mode(MODE_REFLECT,   '{ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0});
    send_mode(MODE_REFRACT,   '{0, -ONE, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE});
    send_mode(MODE_REFRACT,   '{ONE*7/10, -ONE*7/10, 0, 0, ONE, 0, 0, 0, 0, 3*ONE/2, ONE});
    send_mode(MODE_REFRACT,   '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0});
    send_mode(MODE_REFRACT,   '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, -ONE, 0});
    send_mode(4'd13,          '{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_mode(4'd15,          '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});

    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND - 120) idle_en = 1'b0;
      send_random();
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fpv_pkg.sv
design/fpv_dly.sv
design/fpv_mul.sv
design/fpv_div.sv
design/fpv_sqrt.sv
design/fpv_lane.sv
design/fixed_point_vec3_unit.sv
design/fpv_chk.sv
dv/testbench.sv
